### rtl/terh_pkg.sv
// Shared types, codes and field layouts of the touch event region hit test block.
package terh_pkg;

	// Stream and configuration widths.
	localparam int S_TDATA_W = 128;
	localparam int M_TDATA_W = 40;
	localparam int M_FIELD_W = 37;
	localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;
	localparam int CFG_IDX_W = 3;
	localparam int REGION_W  = 64;

	// Input selector codes.
	localparam logic OP_EVENT  = 1'b0;
	localparam logic OP_REGION = 1'b1;

	// Event type and code values of interest.
	localparam logic [15:0] EV_KEY    = 16'd1;
	localparam logic [15:0] EV_ABS    = 16'd3;
	localparam logic [15:0] KEY_TOUCH = 16'd330;
	localparam logic [15:0] ABS_X     = 16'd0;
	localparam logic [15:0] ABS_Y     = 16'd1;

	// Result kinds.
	localparam logic [1:0] KIND_RELEASE = 2'd0;
	localparam logic [1:0] KIND_ADDED   = 2'd1;
	localparam logic [1:0] KIND_FULL    = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_X_SLOPE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_SLOPE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 3'd3;

	// Calibration reset values, signed Q16.16.
	localparam logic signed [31:0] X_SLOPE_RST  = -32'sd8427;
	localparam logic signed [31:0] X_OFFSET_RST = 32'sd33146837;
	localparam logic signed [31:0] Y_SLOPE_RST  = 32'sd5681;
	localparam logic signed [31:0] Y_OFFSET_RST = -32'sd1242432;

	// Tag that travels with a request through the mapping pipeline.
	typedef struct packed {
		logic valid;
		logic axis_y;
	} map_tag_t;

endpackage

### rtl/touch_event_region_hit_test.sv
// Top level of the touch release mapping and region hit test block.
//
//  Channel   Direction  Handshake              Payload
//  s_*       in         s_tvalid / s_tready    s_tdata (event or region), s_tuser (opcode)
//  m_*       out        m_tvalid / m_tready    m_tdata (hit, index, pixels), m_tuser (kind)
//  cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data (calibration registers)
//
// An axis or ignored event is handled in idle; a region add also passes through the emit state.
// A touch release goes through two issues into the mapping pipeline, its three stages,
// one region table read per cycle until a hit or the last entry (none when empty), then emit.
// The region table is a memory with a single read port and a registered read.
// No clearing pass after reset: only entries below the fill count are read.
// A finished result waits in the output register while the next request is taken.
module touch_event_region_hit_test #(
	parameter int MAX_REGIONS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// event_type, event_code, event_value, region_left, region_top,
	// region_right, region_bottom
	input  logic [terh_pkg::S_TDATA_W-1:0]      s_tdata,
	// opcode
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// hit, region_index, pixel_x, pixel_y, zero fill
	output logic [terh_pkg::M_TDATA_W-1:0]      m_tdata,
	// kind
	output logic [1:0]                          m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [terh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data
);
	import terh_pkg::*;

	localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAPY = 3'd1;
	localparam logic [2:0] ST_MAPW = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         scan_idx_q;
	logic signed [31:0]    raw_x_q, raw_y_q;
	logic signed [31:0]    x_slope_q, x_offset_q, y_slope_q, y_offset_q;
	logic [REGION_W-1:0]   region_mem [MAX_REGIONS];
	logic [REGION_W-1:0]   rd_data_s1;
	logic                  rd_valid_s1, rd_last_s1;
	logic [AW-1:0]         rd_idx_s1;
	logic [1:0]            res_kind_q;
	logic                  res_hit_q;
	logic [3:0]            res_idx_q;
	logic signed [15:0]    px_q, py_q;
	logic                  m_valid_q;
	logic [1:0]            m_kind_q;
	logic [M_TDATA_W-1:0]  m_data_q;

	logic                  accept, is_release, table_full, mem_we, rd_en, region_hit, out_free;
	logic [15:0]           ev_type, ev_code;
	logic signed [31:0]    ev_value;
	logic [AW+3:0]         rd_idx_ext;
	logic [CW+3:0]         count_ext;
	map_tag_t              map_req, map_rsp;
	logic signed [31:0]    map_raw, map_slope, map_offset;
	logic signed [15:0]    map_pixel;
	logic signed [15:0]    r_left, r_top, r_right, r_bottom;

	// Request decode.
	assign s_tready   = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign accept     = s_tvalid && s_tready;
	assign ev_type    = s_tdata[15:0];
	assign ev_code    = s_tdata[31:16];
	assign ev_value   = s_tdata[63:32];
	assign is_release = (s_tuser == OP_EVENT) && (ev_type == EV_KEY) &&
		(ev_code == KEY_TOUCH) && (ev_value == 32'sd0);
	assign table_full = (count_q >= MAX_CNT);
	assign mem_we     = accept && (s_tuser == OP_REGION) && !table_full;
	assign out_free   = !m_valid_q || m_tready;
	assign count_ext  = {4'd0, count_q};
	assign rd_idx_ext = {4'd0, rd_idx_s1};

	// X goes into the mapping pipeline with the release, Y in the following cycle.
	always_comb begin
		map_req.valid  = (accept && is_release) || (state_q == ST_MAPY);
		map_req.axis_y = (state_q == ST_MAPY);
		map_raw        = map_req.axis_y ? raw_y_q : raw_x_q;
		map_slope      = map_req.axis_y ? y_slope_q : x_slope_q;
		map_offset     = map_req.axis_y ? y_offset_q : x_offset_q;
	end

	terh_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (map_req),
		.raw    (map_raw),
		.slope  (map_slope),
		.offset (map_offset),
		.rsp    (map_rsp),
		.pixel  (map_pixel)
	);

	// Region table. Adds happen only in idle and reads only while scanning,
	// so a read never meets a write to the same entry.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			region_mem[count_q[AW-1:0]] <= s_tdata[S_TDATA_W-1:S_TDATA_W-REGION_W];
		end
	end

	assign rd_en = (state_q == ST_SCAN) && (scan_idx_q < count_q);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= region_mem[scan_idx_q[AW-1:0]];
		end
	end

	// Inclusive rectangle test against the entry just read.
	always_comb begin
		r_left     = rd_data_s1[15:0];
		r_top      = rd_data_s1[31:16];
		r_right    = rd_data_s1[47:32];
		r_bottom   = rd_data_s1[63:48];
		region_hit = (px_q >= r_left) && (py_q >= r_top) &&
			(px_q <= r_right) && (py_q <= r_bottom);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_slope_q  <= X_SLOPE_RST;
			x_offset_q <= X_OFFSET_RST;
			y_slope_q  <= Y_SLOPE_RST;
			y_offset_q <= Y_OFFSET_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_X_SLOPE:  x_slope_q  <= cfg_data;
				CFG_X_OFFSET: x_offset_q <= cfg_data;
				CFG_Y_SLOPE:  y_slope_q  <= cfg_data;
				CFG_Y_OFFSET: y_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, fill count, raw coordinates and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_idx_q  <= '0;
			raw_x_q     <= '0;
			raw_y_q     <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			rd_idx_s1   <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (rd_en) begin
				rd_last_s1 <= (CW'(scan_idx_q + 1'b1) == count_q);
				rd_idx_s1  <= scan_idx_q[AW-1:0];
				scan_idx_q <= CW'(scan_idx_q + 1'b1);
			end
			// The output register fills on emit and empties when the receiver takes it.
			if ((state_q == ST_EMIT) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == OP_REGION) begin
							if (!table_full) begin
								count_q <= CW'(count_q + 1'b1);
							end
							state_q <= ST_EMIT;
						end else if (ev_type == EV_ABS) begin
							if (ev_code == ABS_X) begin
								raw_x_q <= ev_value;
							end else if (ev_code == ABS_Y) begin
								raw_y_q <= ev_value;
							end
						end else if (is_release) begin
							state_q <= ST_MAPY;
						end
					end
				end
				ST_MAPY: begin
					state_q <= ST_MAPW;
				end
				ST_MAPW: begin
					if (map_rsp.valid && map_rsp.axis_y) begin
						scan_idx_q <= '0;
						state_q    <= (count_q == '0) ? ST_EMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_valid_s1 && (region_hit || rd_last_s1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result fields and the output register.
	always_ff @(posedge clk) begin
		if (accept && (s_tuser == OP_REGION)) begin
			res_kind_q <= table_full ? KIND_FULL : KIND_ADDED;
			res_hit_q  <= 1'b0;
			res_idx_q  <= table_full ? 4'd0 : count_ext[3:0];
			px_q       <= '0;
			py_q       <= '0;
		end else if (accept && is_release) begin
			res_kind_q <= KIND_RELEASE;
			res_hit_q  <= 1'b0;
			res_idx_q  <= 4'd0;
		end
		if ((state_q == ST_MAPW) && map_rsp.valid) begin
			if (map_rsp.axis_y) begin
				py_q <= map_pixel;
			end else begin
				px_q <= map_pixel;
			end
		end
		if ((state_q == ST_SCAN) && rd_valid_s1 && region_hit) begin
			res_hit_q <= 1'b1;
			res_idx_q <= rd_idx_ext[3:0];
		end
		if ((state_q == ST_EMIT) && out_free) begin
			m_kind_q <= res_kind_q;
			m_data_q <= {{M_PAD_W{1'b0}}, py_q, px_q, res_idx_q, res_hit_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;

endmodule

### rtl/terh_map.sv
// Three-stage pipeline mapping a raw coordinate to a saturated pixel.
module terh_map (
	input  logic                  clk,
	input  logic                  arst_n,
	input  terh_pkg::map_tag_t    req,
	input  logic signed [31:0]    raw,
	input  logic signed [31:0]    slope,
	input  logic signed [31:0]    offset,
	output terh_pkg::map_tag_t    rsp,
	output logic signed [15:0]    pixel
);
	import terh_pkg::*;

	map_tag_t           tag_s1, tag_s2, tag_s3;
	logic signed [63:0] prod_s1;
	logic signed [31:0] off_s1;
	logic signed [63:0] acc_s2;
	logic signed [15:0] pix_s3;
	logic signed [47:0] quot;
	logic               fits;

	// Tags carry the valid flag, so they are reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= req;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// Divide by 65536 rounding toward zero: bump a negative quotient with a remainder.
	always_comb begin
		quot = acc_s2[63:16] + {47'd0, (acc_s2[63] & (|acc_s2[15:0]))};
		fits = (quot[47:15] == '0) || (quot[47:15] == '1);
	end

	// Multiply, add offset, then scale and saturate.
	always_ff @(posedge clk) begin
		prod_s1 <= raw * slope;
		off_s1  <= offset;
		acc_s2  <= prod_s1 + {{32{off_s1[31]}}, off_s1};
		if (fits) begin
			pix_s3 <= quot[15:0];
		end else if (quot[47]) begin
			pix_s3 <= 16'sh8000;
		end else begin
			pix_s3 <= 16'sh7fff;
		end
	end

	assign rsp   = tag_s3;
	assign pixel = pix_s3;

endmodule

### rtl/terh_checker.sv
// Port-level checker for the hit test block and its bind to the top level.
module terh_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                s_tuser,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [terh_pkg::M_TDATA_W-1:0]      m_tdata,
	input logic [1:0]                          m_tuser
);
	import terh_pkg::*;

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Region add and full results carry no hit and no pixels.
	a_add_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_RELEASE) |-> (m_tdata[0] == 1'b0) &&
		(m_tdata[36:5] == '0))
		else $error("region add result carries hit or pixel bits");

	// A miss or a full table reports index zero.
	a_miss_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == KIND_FULL) || ((m_tuser == KIND_RELEASE) && !m_tdata[0]))
		|-> (m_tdata[4:1] == 4'd0))
		else $error("nonzero index on miss or full table");

	// A region add always produces a result, so the input side closes next cycle.
	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_REGION) |=> !s_tready)
		else $error("input ready right after region add");

endmodule

bind touch_event_region_hit_test terh_checker u_terh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
